[rtl/mips64_integer_core_subset_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the integer core
// Checks are clocked on i_clk and disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef MIPS64_INTEGER_CORE_SUBSET_ASSERT_SVH
`define MIPS64_INTEGER_CORE_SUBSET_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define MICS_IMPLY(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define MICS_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[rtl/mics_pkg.sv]
// ----------------------------------------------------------------------------
// mics_pkg
// Shared types and codes of the integer core.
// ----------------------------------------------------------------------------
package mics_pkg;

    localparam logic [31:0] START_PC_RESET = 32'hBFC0_0000;

    // result kinds
    localparam logic [2:0] K_RETIRED = 3'd0;
    localparam logic [2:0] K_READ    = 3'd1;
    localparam logic [2:0] K_WRITE   = 3'd2;
    localparam logic [2:0] K_SYSCALL = 3'd3;
    localparam logic [2:0] K_ERROR   = 3'd4;

    // error codes
    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_UNIMP = 2'd1;
    localparam logic [1:0] E_ALIGN = 2'd2;
    localparam logic [1:0] E_DIV0  = 2'd3;

    // access sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_DBL  = 2'd3;

    // pending load kinds
    localparam logic [2:0] LK_NONE = 3'd0;
    localparam logic [2:0] LK_LB   = 3'd1;
    localparam logic [2:0] LK_LH   = 3'd2;
    localparam logic [2:0] LK_LW   = 3'd3;
    localparam logic [2:0] LK_LBU  = 3'd4;
    localparam logic [2:0] LK_LHU  = 3'd5;
    localparam logic [2:0] LK_LD   = 3'd6;

    // major opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_BEQL    = 6'h14;
    localparam logic [5:0] OP_BNEL    = 6'h15;
    localparam logic [5:0] OP_SQ      = 6'h1F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;
    localparam logic [5:0] OP_LD      = 6'h37;
    localparam logic [5:0] OP_SWC1    = 6'h39;
    localparam logic [5:0] OP_SD      = 6'h3F;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_MOVN    = 6'h0B;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_SYNC    = 6'h0F;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;
    localparam logic [5:0] FN_DADDU   = 6'h2D;
    localparam logic [5:0] FN_DSLL    = 6'h38;
    localparam logic [5:0] FN_DSRL    = 6'h3A;
    localparam logic [5:0] FN_DSLL32  = 6'h3C;
    localparam logic [5:0] FN_DSRL32  = 6'h3E;

    // COP0 rs codes and functions
    localparam logic [4:0] C0_MF    = 5'h00;
    localparam logic [4:0] C0_MT    = 5'h04;
    localparam logic [4:0] C0_CO    = 5'h10;
    localparam logic [5:0] FN_TLBWI = 6'h02;
    localparam logic [5:0] FN_EI    = 6'h38;
    localparam logic [4:0] C0_PRID  = 5'd15;
    localparam logic [63:0] PRID_VALUE = 64'h69;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_V1   = 5'd3;
    localparam logic [4:0] REG_RA   = 5'd31;

    typedef enum logic [1:0] {
        CLS_PLAIN,
        CLS_MULT,
        CLS_DIVU
    } t_cls;

    // classified transaction from front to back
    typedef struct packed {
        logic        mode;
        logic [31:0] word;
        logic [63:0] ldata;
        t_cls        cls;
        logic [4:0]  ra;
        logic [4:0]  rb;
    } t_fq;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] addr;
        logic [63:0] data;
        logic [1:0]  size;
        logic [31:0] npc;
        logic [1:0]  err;
        logic        last;
    } t_res;

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

[rtl/mips64_integer_core_subset.sv]
// ----------------------------------------------------------------------------
// mips64_integer_core_subset
// Small MIPS64 integer core with queue-style instruction and result sides.
// ----------------------------------------------------------------------------
// A transaction (instruction word or load data) passes two steps in the back
// end: one reads the register file, one executes and queues its result.
// MULT adds a step to write HI/LO from the registered product, DIVU adds
// the steps of the one-bit-per-cycle divider, and SQ adds a step for its
// second write request. The front queue holds two transactions and the
// result queue four; execution waits while the result queue is full.
module mips64_integer_core_subset (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [31:0] i_instr_word,
    input  logic [63:0] i_load_data,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [31:0] o_mem_address,
    output logic [63:0] o_write_data,
    output logic [1:0]  o_access_size,
    output logic [31:0] o_next_pc,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    `include "mips64_integer_core_subset_assert.svh"

    mics_pkg::t_fq  fq;
    logic           fq_vld, fq_pop;
    mics_pkg::t_res res_in, res_out;
    logic           res_push, res_full;

    mics_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_mode       (i_mode),
        .i_instr_word (i_instr_word),
        .i_load_data  (i_load_data),
        .o_full       (full),
        .o_vld        (fq_vld),
        .o_fq         (fq),
        .i_pop        (fq_pop)
    );

    mics_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fq_vld    (fq_vld),
        .i_fq        (fq),
        .o_fq_pop    (fq_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    mics_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .o_res   (res_out),
        .i_pop   (pop)
    );

    assign o_kind        = res_out.kind;
    assign o_mem_address = res_out.addr;
    assign o_write_data  = res_out.data;
    assign o_access_size = res_out.size;
    assign o_next_pc     = res_out.npc;
    assign o_error_code  = res_out.err;
    assign o_last        = res_out.last;

    `MICS_IMPLY(a_read_is_last, !empty && o_kind == mics_pkg::K_READ, o_last,
                "read request not last")
    `MICS_IMPLY(a_err_kind, !empty && o_error_code != mics_pkg::E_NONE,
                o_kind == mics_pkg::K_ERROR, "error code without error kind")
    `MICS_NEXT(a_sq_pair, pop && !empty && !o_last,
               !empty && o_kind == mics_pkg::K_WRITE, "second SQ write missing")

endmodule

[rtl/mics_front.sv]
// ----------------------------------------------------------------------------
// mics_front
// Accepts transactions, picks register read ports and execution class,
// and buffers them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mics_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_mode,
    input  logic [31:0]       i_instr_word,
    input  logic [63:0]       i_load_data,
    output logic              o_full,
    output logic              o_vld,
    output mics_pkg::t_fq     o_fq,
    input  logic              i_pop
);

    mics_pkg::t_fq r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    mics_pkg::t_fq n_item;
    logic          wr_en, rd_en;

    always_comb begin
        n_item.mode  = i_mode;
        n_item.word  = i_instr_word;
        n_item.ldata = i_load_data;
        n_item.rb    = i_instr_word[20:16];
        n_item.ra    = i_instr_word[25:21];
        n_item.cls   = mics_pkg::CLS_PLAIN;
        if (i_instr_word[31:26] == mics_pkg::OP_SPECIAL) begin
            case (i_instr_word[5:0])
                mics_pkg::FN_SYSCALL: n_item.ra  = mics_pkg::REG_V1;
                mics_pkg::FN_MULT:    n_item.cls = mics_pkg::CLS_MULT;
                mics_pkg::FN_DIVU:    n_item.cls = mics_pkg::CLS_DIVU;
                default:              n_item.cls = mics_pkg::CLS_PLAIN;
            endcase
        end
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_fq   = r_q[r_rp];
    assign wr_en  = i_push && !o_full;
    assign rd_en  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) r_wp <= ~r_wp;
            if (rd_en) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule

[rtl/mics_outq.sv]
// ----------------------------------------------------------------------------
// mics_outq
// Four-entry result queue between the back end and the result ports.
// ----------------------------------------------------------------------------
module mics_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mics_pkg::t_res i_res,
    output logic           o_full,
    output logic           o_empty,
    output mics_pkg::t_res o_res,
    input  logic           i_pop
);

    mics_pkg::t_res r_q [4];
    logic [1:0]     r_wp, r_rp;
    logic [2:0]     r_cnt;
    logic           wr_en, rd_en;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_res   = r_q[r_rp];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wp] <= i_res;
        end
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (wr_en) r_wp <= r_wp + 2'd1;
            if (rd_en) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, wr_en} - {2'b0, rd_en};
        end
    end

endmodule

[rtl/mics_back.sv]
// ----------------------------------------------------------------------------
// mics_back
// Execution end: register file, HI/LO, pc and branch state, multiplier
// and a bit-serial unsigned divider.
// ----------------------------------------------------------------------------
module mics_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_wdata,
    input  logic           i_fq_vld,
    input  mics_pkg::t_fq  i_fq,
    output logic           o_fq_pop,
    input  logic           i_res_full,
    output logic           o_res_push,
    output mics_pkg::t_res o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_SQ2
    } t_state;

    t_state         r_state;
    logic [63:0]    r_rf [32];
    logic [31:0]    r_rf_vld;
    logic [63:0]    r_hi, r_lo, r_a, r_b;
    logic [31:0]    r_pc, r_btgt;
    logic           r_bpend;
    logic [4:0]     r_ldest;
    logic [2:0]     r_lkind;
    mics_pkg::t_fq  r_item;
    logic [63:0]    r_prod;
    logic [32:0]    r_rem;
    logic [31:0]    r_quo, r_dvs;
    logic [4:0]     r_cnt;
    mics_pkg::t_res r_sq2;

    // decoded fields
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [15:0] imm;
    logic [63:0] sximm;
    logic [31:0] pc4, btgt, addr, base, npc;
    logic [2:0]  mask;

    // execution results
    logic        wen, take, skip, two, ignore, go;
    logic [4:0]  wdst;
    logic [63:0] wval, data, ldval;
    logic [31:0] tgt, maddr;
    logic [2:0]  kind, lk;
    logic [1:0]  err, size;
    mics_pkg::t_res res;

    // divider step
    logic [32:0] rem_sh, rem_sub;

    assign op    = r_item.word[31:26];
    assign rs    = r_item.word[25:21];
    assign rt    = r_item.word[20:16];
    assign rd    = r_item.word[15:11];
    assign sa    = r_item.word[10:6];
    assign fn    = r_item.word[5:0];
    assign imm   = r_item.word[15:0];
    assign sximm = {{48{imm[15]}}, imm};
    assign pc4   = r_pc + 32'd4;
    assign btgt  = pc4 + {{14{imm[15]}}, imm, 2'b00};
    assign addr  = r_a[31:0] + sximm[31:0];
    assign base  = r_bpend ? r_btgt : pc4;

    always_comb begin
        case (r_lkind)
            mics_pkg::LK_LB:  ldval = {{56{r_item.ldata[7]}}, r_item.ldata[7:0]};
            mics_pkg::LK_LH:  ldval = {{48{r_item.ldata[15]}}, r_item.ldata[15:0]};
            mics_pkg::LK_LW:  ldval = mics_pkg::sx32(r_item.ldata[31:0]);
            mics_pkg::LK_LBU: ldval = {56'b0, r_item.ldata[7:0]};
            mics_pkg::LK_LHU: ldval = {48'b0, r_item.ldata[15:0]};
            default:          ldval = r_item.ldata;
        endcase
    end

    always_comb begin
        wen  = 1'b0;
        wdst = rd;
        wval = '0;
        take = 1'b0;
        skip = 1'b0;
        two  = 1'b0;
        tgt  = '0;
        kind = mics_pkg::K_RETIRED;
        err  = mics_pkg::E_NONE;
        size = mics_pkg::SZ_BYTE;
        lk   = mics_pkg::LK_NONE;
        data = '0;
        maddr = '0;
        case (op)
            mics_pkg::OP_SPECIAL: begin
                case (fn)
                    mics_pkg::FN_SLL: begin
                        wen = 1'b1; wval = mics_pkg::sx32(r_b[31:0] << sa);
                    end
                    mics_pkg::FN_SRL: begin
                        wen = 1'b1; wval = mics_pkg::sx32(r_b[31:0] >> sa);
                    end
                    mics_pkg::FN_SRA: begin
                        wen = 1'b1; wval = mics_pkg::sx32($signed(r_b[31:0]) >>> sa);
                    end
                    mics_pkg::FN_JR: begin
                        take = 1'b1; tgt = r_a[31:0];
                    end
                    mics_pkg::FN_JALR: begin
                        take = 1'b1; tgt = r_a[31:0];
                        wen = 1'b1; wval = {32'b0, r_pc + 32'd8};
                    end
                    mics_pkg::FN_MOVN: begin
                        wen = (r_b != 64'd0); wval = r_a;
                    end
                    mics_pkg::FN_SYSCALL: begin
                        kind = mics_pkg::K_SYSCALL; data = r_a;
                    end
                    mics_pkg::FN_SYNC, mics_pkg::FN_MULT: ;
                    mics_pkg::FN_MFHI: begin
                        wen = 1'b1; wval = r_hi;
                    end
                    mics_pkg::FN_MFLO: begin
                        wen = 1'b1; wval = r_lo;
                    end
                    mics_pkg::FN_DIVU: begin
                        if (r_b[31:0] == 32'd0) begin
                            kind = mics_pkg::K_ERROR; err = mics_pkg::E_DIV0;
                        end
                    end
                    mics_pkg::FN_ADD, mics_pkg::FN_ADDU: begin
                        wen = 1'b1; wval = mics_pkg::sx32(r_a[31:0] + r_b[31:0]);
                    end
                    mics_pkg::FN_SUB, mics_pkg::FN_SUBU: begin
                        wen = 1'b1; wval = mics_pkg::sx32(r_a[31:0] - r_b[31:0]);
                    end
                    mics_pkg::FN_AND: begin
                        wen = 1'b1; wval = r_a & r_b;
                    end
                    mics_pkg::FN_OR: begin
                        wen = 1'b1; wval = r_a | r_b;
                    end
                    mics_pkg::FN_SLT: begin
                        wen = 1'b1; wval = {63'b0, $signed(r_a) < $signed(r_b)};
                    end
                    mics_pkg::FN_SLTU: begin
                        wen = 1'b1; wval = {63'b0, r_a < r_b};
                    end
                    mics_pkg::FN_DADDU: begin
                        wen = 1'b1; wval = r_a + r_b;
                    end
                    mics_pkg::FN_DSLL: begin
                        wen = 1'b1; wval = r_b << sa;
                    end
                    mics_pkg::FN_DSRL: begin
                        wen = 1'b1; wval = r_b >> sa;
                    end
                    mics_pkg::FN_DSLL32: begin
                        wen = 1'b1; wval = r_b << {1'b1, sa};
                    end
                    mics_pkg::FN_DSRL32: begin
                        wen = 1'b1; wval = r_b >> {1'b1, sa};
                    end
                    default: begin
                        kind = mics_pkg::K_ERROR; err = mics_pkg::E_UNIMP;
                    end
                endcase
            end
            mics_pkg::OP_REGIMM: begin
                if (rt == 5'd0) begin
                    take = r_a[63]; tgt = btgt;
                end else if (rt == 5'd1) begin
                    take = !r_a[63]; tgt = btgt;
                end else begin
                    kind = mics_pkg::K_ERROR; err = mics_pkg::E_UNIMP;
                end
            end
            mics_pkg::OP_J, mics_pkg::OP_JAL: begin
                take = 1'b1;
                tgt  = {pc4[31:28], r_item.word[25:0], 2'b00};
                wen  = (op == mics_pkg::OP_JAL);
                wdst = mics_pkg::REG_RA;
                wval = {32'b0, r_pc + 32'd8};
            end
            mics_pkg::OP_BEQ:  begin take = (r_a == r_b); tgt = btgt; end
            mics_pkg::OP_BNE:  begin take = (r_a != r_b); tgt = btgt; end
            mics_pkg::OP_BLEZ: begin take = r_a[63] || (r_a == 64'd0); tgt = btgt; end
            mics_pkg::OP_BGTZ: begin take = !r_a[63] && (r_a != 64'd0); tgt = btgt; end
            mics_pkg::OP_ADDI, mics_pkg::OP_ADDIU: begin
                wen = 1'b1; wdst = rt; wval = mics_pkg::sx32(addr);
            end
            mics_pkg::OP_SLTI: begin
                wen = 1'b1; wdst = rt; wval = {63'b0, $signed(r_a) < $signed(sximm)};
            end
            mics_pkg::OP_SLTIU: begin
                wen = 1'b1; wdst = rt; wval = {63'b0, r_a < sximm};
            end
            mics_pkg::OP_ANDI: begin
                wen = 1'b1; wdst = rt; wval = r_a & {48'b0, imm};
            end
            mics_pkg::OP_ORI: begin
                wen = 1'b1; wdst = rt; wval = r_a | {48'b0, imm};
            end
            mics_pkg::OP_LUI: begin
                wen = 1'b1; wdst = rt; wval = mics_pkg::sx32({imm, 16'b0});
            end
            mics_pkg::OP_COP0: begin
                wdst = rt;
                wval = mics_pkg::PRID_VALUE;
                if (rs == mics_pkg::C0_MF) begin
                    wen = (rd == mics_pkg::C0_PRID);
                end else if (rs == mics_pkg::C0_MT) begin
                    wen = 1'b0;
                end else if (rs == mics_pkg::C0_CO &&
                             (fn == mics_pkg::FN_TLBWI || fn == mics_pkg::FN_EI)) begin
                    wen = 1'b0;
                end else begin
                    kind = mics_pkg::K_ERROR; err = mics_pkg::E_UNIMP;
                end
            end
            mics_pkg::OP_BEQL: begin
                take = (r_a == r_b); skip = !take; tgt = btgt;
            end
            mics_pkg::OP_BNEL: begin
                take = (r_a != r_b); skip = !take; tgt = btgt;
            end
            mics_pkg::OP_SQ: begin
                kind = mics_pkg::K_WRITE; size = mics_pkg::SZ_DBL;
                maddr = {addr[31:4], 4'b0}; data = r_b; two = 1'b1;
            end
            mics_pkg::OP_LB:  begin lk = mics_pkg::LK_LB;  size = mics_pkg::SZ_BYTE; end
            mics_pkg::OP_LH:  begin lk = mics_pkg::LK_LH;  size = mics_pkg::SZ_HALF; end
            mics_pkg::OP_LW:  begin lk = mics_pkg::LK_LW;  size = mics_pkg::SZ_WORD; end
            mics_pkg::OP_LBU: begin lk = mics_pkg::LK_LBU; size = mics_pkg::SZ_BYTE; end
            mics_pkg::OP_LHU: begin lk = mics_pkg::LK_LHU; size = mics_pkg::SZ_HALF; end
            mics_pkg::OP_LD:  begin lk = mics_pkg::LK_LD;  size = mics_pkg::SZ_DBL;  end
            mics_pkg::OP_SB: begin
                kind = mics_pkg::K_WRITE; size = mics_pkg::SZ_BYTE; data = {56'b0, r_b[7:0]};
            end
            mics_pkg::OP_SH: begin
                kind = mics_pkg::K_WRITE; size = mics_pkg::SZ_HALF; data = {48'b0, r_b[15:0]};
            end
            mics_pkg::OP_SW: begin
                kind = mics_pkg::K_WRITE; size = mics_pkg::SZ_WORD; data = {32'b0, r_b[31:0]};
            end
            mics_pkg::OP_SD: begin
                kind = mics_pkg::K_WRITE; size = mics_pkg::SZ_DBL; data = r_b;
            end
            mics_pkg::OP_SWC1: ;
            default: begin
                kind = mics_pkg::K_ERROR; err = mics_pkg::E_UNIMP;
            end
        endcase

        if (lk != mics_pkg::LK_NONE) kind = mics_pkg::K_READ;
        mask = 3'((4'd1 << size) - 4'd1);
        if ((kind == mics_pkg::K_READ || kind == mics_pkg::K_WRITE) && !two) begin
            maddr = addr;
            if ((addr[2:0] & mask) != 3'd0) begin
                kind = mics_pkg::K_ERROR; err = mics_pkg::E_ALIGN;
                size = mics_pkg::SZ_BYTE; data = '0; lk = mics_pkg::LK_NONE;
            end
        end
        if (kind == mics_pkg::K_ERROR) begin
            wen = 1'b0; take = 1'b0;
        end
        if (kind == mics_pkg::K_RETIRED || kind == mics_pkg::K_SYSCALL) begin
            size = mics_pkg::SZ_BYTE; maddr = '0;
        end
        npc = base + (skip ? 32'd4 : 32'd0);
    end

    // transactions that produce nothing: instruction while a load waits, stray load data
    assign ignore = r_item.mode ? (r_lkind == mics_pkg::LK_NONE)
                                : (r_lkind != mics_pkg::LK_NONE);
    assign go     = (r_state == S_EXEC) && (ignore || !i_res_full);

    always_comb begin
        if (r_item.mode) begin
            res.kind = mics_pkg::K_RETIRED;
            res.addr = '0;
            res.data = '0;
            res.size = mics_pkg::SZ_BYTE;
            res.npc  = r_pc;
            res.err  = mics_pkg::E_NONE;
            res.last = 1'b1;
        end else begin
            res.kind = kind;
            res.addr = maddr;
            res.data = data;
            res.size = size;
            res.npc  = npc;
            res.err  = err;
            res.last = !two;
        end
    end

    assign o_fq_pop   = (r_state == S_IDLE) && i_fq_vld;
    assign o_res_push = (go && !ignore) || (r_state == S_SQ2 && !i_res_full);
    assign o_res      = (r_state == S_SQ2) ? r_sq2 : res;

    assign rem_sh  = {r_rem[31:0], r_quo[31]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    // register file: read ports registered on pop, single write port
    always_ff @(posedge i_clk) begin
        if (o_fq_pop) begin
            r_a <= r_rf_vld[i_fq.ra] ? r_rf[i_fq.ra] : 64'd0;
            r_b <= r_rf_vld[i_fq.rb] ? r_rf[i_fq.rb] : 64'd0;
        end
        if (go && !ignore) begin
            if (r_item.mode) begin
                if (r_ldest != mics_pkg::REG_ZERO) r_rf[r_ldest] <= ldval;
            end else if (wen && wdst != mics_pkg::REG_ZERO) begin
                r_rf[wdst] <= wval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fq_pop) r_item <= i_fq;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rf_vld <= '0;
            r_hi     <= '0;
            r_lo     <= '0;
            r_pc     <= mics_pkg::START_PC_RESET;
            r_btgt   <= '0;
            r_bpend  <= 1'b0;
            r_ldest  <= '0;
            r_lkind  <= mics_pkg::LK_NONE;
        end else begin
            if (i_cfg_we) r_pc <= i_cfg_wdata;
            case (r_state)
                S_IDLE: begin
                    if (i_fq_vld) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (go) begin
                        r_state <= S_IDLE;
                        if (!ignore && r_item.mode) begin
                            if (r_ldest != mics_pkg::REG_ZERO) r_rf_vld[r_ldest] <= 1'b1;
                            r_lkind <= mics_pkg::LK_NONE;
                        end else if (!ignore) begin
                            if (wen && wdst != mics_pkg::REG_ZERO) r_rf_vld[wdst] <= 1'b1;
                            r_pc    <= npc;
                            r_bpend <= take;
                            if (take) r_btgt <= tgt;
                            if (kind == mics_pkg::K_READ) begin
                                r_lkind <= lk;
                                r_ldest <= rt;
                            end
                            r_sq2.kind <= mics_pkg::K_WRITE;
                            r_sq2.addr <= maddr + 32'd8;
                            r_sq2.data <= '0;
                            r_sq2.size <= mics_pkg::SZ_DBL;
                            r_sq2.npc  <= npc;
                            r_sq2.err  <= mics_pkg::E_NONE;
                            r_sq2.last <= 1'b1;
                            r_prod <= 64'($signed(r_a[31:0]) * $signed(r_b[31:0]));
                            r_rem  <= '0;
                            r_quo  <= r_a[31:0];
                            r_dvs  <= r_b[31:0];
                            r_cnt  <= 5'd31;
                            if (two) begin
                                r_state <= S_SQ2;
                            end else if (r_item.cls == mics_pkg::CLS_MULT) begin
                                r_state <= S_MUL;
                            end else if (r_item.cls == mics_pkg::CLS_DIVU &&
                                         kind != mics_pkg::K_ERROR) begin
                                r_state <= S_DIV;
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_lo    <= mics_pkg::sx32(r_prod[31:0]);
                    r_hi    <= mics_pkg::sx32(r_prod[63:32]);
                    r_state <= S_IDLE;
                end
                S_DIV: begin
                    if (!rem_sub[32]) begin
                        r_rem <= rem_sub;
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_lo    <= mics_pkg::sx32({r_quo[30:0], !rem_sub[32]});
                        r_hi    <= mics_pkg::sx32(rem_sub[32] ? rem_sh[31:0] : rem_sub[31:0]);
                        r_state <= S_IDLE;
                    end
                end
                S_SQ2: begin
                    if (!i_res_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
